@@ rtl/bsp_pkg.sv @@
package bsp_pkg;

	localparam int NODES     = 64;
	localparam int FANOUT    = 3;
	localparam int NODE_W    = $clog2(NODES);
	localparam int ADJ_DEPTH = NODES * FANOUT;
	localparam int ADJ_W     = $clog2(ADJ_DEPTH);
	localparam int K_W       = $clog2(FANOUT + 1);
	localparam int TAIL_W    = $clog2(NODES + 1);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic STATUS_PATH = 1'b0;
	localparam logic STATUS_NC   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic query;
		logic seed;
		logic pop;
		logic scan;
		logic adj_rd;
		logic walk_init;
		logic walk_rd;
		logic walk_wr;
		logic emit_init;
		logic emit_rd;
		logic emit_ld;
		logic nc_ld;
	} bsp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic same_ends;
		logic queue_empty;
		logic scan_done;
		logic found;
		logic pred_ok;
		logic emit_last;
		logic out_free;
	} bsp_status_t;

endpackage

@@ rtl/bsp_ctrl.sv @@
module bsp_ctrl import bsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  bsp_status_t sts,
	output bsp_cmd_t    ctl
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_POP,
		ST_SCAN,
		ST_WALK,
		ST_WALK_WR,
		ST_EMIT,
		ST_EMIT_LD,
		ST_NOCONN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_LOAD) begin
						ctl.load = 1'b1;
					end else begin
						ctl.query = 1'b1;
						state_d   = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				// The start is visited first, so a query to itself never finds the end.
				if (sts.same_ends) begin
					state_d = ST_NOCONN;
				end else begin
					ctl.seed = 1'b1;
					state_d  = ST_POP;
				end
			end
			ST_POP: begin
				if (sts.queue_empty) begin
					state_d = ST_NOCONN;
				end else begin
					ctl.pop = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.found) begin
					ctl.walk_init = 1'b1;
					state_d       = ST_WALK;
				end else if (sts.scan_done) begin
					state_d = ST_POP;
				end else begin
					ctl.adj_rd = 1'b1;
				end
			end
			ST_WALK: begin
				if (sts.pred_ok) begin
					ctl.walk_rd = 1'b1;
					state_d     = ST_WALK_WR;
				end else begin
					ctl.emit_init = 1'b1;
					state_d       = ST_EMIT;
				end
			end
			ST_WALK_WR: begin
				ctl.walk_wr = 1'b1;
				state_d     = ST_WALK;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit_rd = 1'b1;
					state_d     = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: begin
				ctl.emit_ld = 1'b1;
				state_d     = sts.emit_last ? ST_IDLE : ST_EMIT;
			end
			ST_NOCONN: begin
				if (sts.out_free) begin
					ctl.nc_ld = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/bsp_datapath.sv @@
module bsp_datapath import bsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bsp_cmd_t          ctl,
	output bsp_status_t       sts,
	input  logic [5:0]        node,
	input  logic [1:0]        slot,
	input  logic [5:0]        successor,
	input  logic              succ_valid,
	input  logic [5:0]        start_req,
	input  logic [5:0]        end_node,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [5:0]        path_node,
	output logic              status,
	output logic              last
);

	logic [ADJ_DEPTH-1:0] adj_valid_q;
	logic [NODE_W-1:0]    adj_mem [ADJ_DEPTH];
	logic [NODES-1:0]     visited_q;
	logic [NODES-1:0]     pred_valid_q;
	logic [NODE_W-1:0]    pred_mem [NODES];
	logic [NODE_W-1:0]    queue_mem [NODES];

	logic [NODE_W-1:0] start_q;
	logic [NODE_W-1:0] end_q;
	logic [TAIL_W-1:0] head_q;
	logic [TAIL_W-1:0] tail_q;
	logic [NODE_W-1:0] qrd_q;
	logic [K_W-1:0]    k_q;
	logic [NODE_W-1:0] adj_succ_s1;
	logic              adj_v_s1;
	logic              chk_s1;
	logic [NODE_W-1:0] c_q;
	logic [NODE_W-1:0] prd_q;
	logic [NODE_W-1:0] cnt_q;
	logic [NODE_W-1:0] idx_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] path_node_q;
	logic              status_q;
	logic              last_q;

	logic [ADJ_W-1:0]  load_idx;
	logic              load_ok;
	logic [ADJ_W-1:0]  scan_idx;
	logic              discover;
	logic              tail_room;
	logic              q_we;
	logic [NODE_W-1:0] q_waddr;
	logic [NODE_W-1:0] q_wdata;
	logic [NODE_W-1:0] q_raddr;

	assign load_idx  = ADJ_W'(node) * ADJ_W'(FANOUT) + ADJ_W'(slot);
	assign load_ok   = int'(slot) < FANOUT;
	// qrd_q holds the node being expanded while the scan runs.
	assign scan_idx  = ADJ_W'(qrd_q) * ADJ_W'(FANOUT) + ADJ_W'(k_q);
	assign discover  = ctl.scan && chk_s1 && adj_v_s1 && !visited_q[adj_succ_s1];
	assign tail_room = int'(tail_q) < NODES;

	// The queue memory holds the frontier during the search and the reversed
	// predecessor chain afterwards.
	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_q[NODE_W-1:0];
		q_wdata = adj_succ_s1;
		if (ctl.seed) begin
			q_we    = 1'b1;
			q_wdata = start_q;
		end else if (discover && tail_room) begin
			q_we = 1'b1;
		end else if (ctl.walk_wr) begin
			q_we    = 1'b1;
			q_waddr = cnt_q;
			q_wdata = prd_q;
		end
	end

	assign q_raddr = ctl.emit_rd ? idx_q : head_q[NODE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_valid_q  <= '0;
			visited_q    <= '0;
			pred_valid_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			k_q          <= '0;
			chk_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.load && load_ok) begin
				adj_valid_q[load_idx] <= succ_valid;
			end
			if (ctl.query) begin
				visited_q    <= '0;
				pred_valid_q <= '0;
				head_q       <= '0;
				tail_q       <= '0;
			end
			if (ctl.seed) begin
				visited_q[start_q] <= 1'b1;
				tail_q             <= TAIL_W'(1);
			end
			if (ctl.pop) begin
				head_q <= head_q + TAIL_W'(1);
			end
			if (discover) begin
				visited_q[adj_succ_s1]    <= 1'b1;
				pred_valid_q[adj_succ_s1] <= 1'b1;
				if (tail_room) begin
					tail_q <= tail_q + TAIL_W'(1);
				end
			end
			if (ctl.pop) begin
				k_q <= '0;
			end else if (ctl.adj_rd) begin
				k_q <= k_q + K_W'(1);
			end
			chk_s1 <= ctl.adj_rd;
			if (ctl.emit_ld || ctl.nc_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.query) begin
			start_q <= start_req;
			end_q   <= end_node;
		end
		if (ctl.adj_rd) begin
			adj_succ_s1 <= adj_mem[scan_idx];
			adj_v_s1    <= adj_valid_q[scan_idx];
		end
		if (ctl.pop || ctl.emit_rd) begin
			qrd_q <= queue_mem[q_raddr];
		end
		if (ctl.walk_init) begin
			c_q   <= end_q;
			cnt_q <= '0;
		end
		if (ctl.walk_rd) begin
			prd_q <= pred_mem[c_q];
		end
		if (ctl.walk_wr) begin
			c_q   <= prd_q;
			cnt_q <= cnt_q + NODE_W'(1);
		end
		if (ctl.emit_init) begin
			idx_q <= cnt_q - NODE_W'(1);
		end
		if (ctl.emit_ld) begin
			idx_q       <= idx_q - NODE_W'(1);
			path_node_q <= qrd_q;
			status_q    <= STATUS_PATH;
			last_q      <= (idx_q == '0);
		end
		if (ctl.nc_ld) begin
			path_node_q <= '0;
			status_q    <= STATUS_NC;
			last_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && load_ok && succ_valid) begin
			adj_mem[load_idx] <= successor;
		end
		if (discover) begin
			pred_mem[adj_succ_s1] <= qrd_q;
		end
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
	end

	always_comb begin
		sts.same_ends   = (start_q == end_q);
		sts.queue_empty = (head_q == tail_q);
		sts.scan_done   = (k_q == K_W'(FANOUT));
		sts.found       = discover && (adj_succ_s1 == end_q);
		sts.pred_ok     = pred_valid_q[c_q];
		sts.emit_last   = (idx_q == '0);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

@@ rtl/bfs_shortest_path_engine.sv @@
// Breadth-first shortest path engine for a graph of 64 nodes with three ordered
// successor slots each. A load transfer (cmd 0) writes one slot; the table is
// empty after reset. A query transfer (cmd 1) searches from start_req,
// expanding nodes in queue order and successors in slot order, and stops when
// end_node is first discovered. It then returns the path from the start through
// the end node's predecessor, one result per node with last on the final one;
// an unreachable end, or a start equal to the end, gives one result with status
// 1. Each expanded node takes one queue read and one adjacency read per slot,
// with a registered check; each path node takes a predecessor read and a
// queue write, and each result a queue read and an output load. Input is
// taken only when the previous transfer is done; a finished result waits in
// the output register without blocking the search.
module bfs_shortest_path_engine import bsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [5:0] node,
	input  logic [1:0] slot,
	input  logic [5:0] successor,
	input  logic       succ_valid,
	input  logic [5:0] start_req,
	input  logic [5:0] end_node,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] path_node,
	output logic       status,
	output logic       last
);

	bsp_cmd_t    ctl;
	bsp_status_t sts;

	bsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	bsp_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.node       (node),
		.slot       (slot),
		.successor  (successor),
		.succ_valid (succ_valid),
		.start_req  (start_req),
		.end_node   (end_node),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.path_node  (path_node),
		.status     (status),
		.last       (last)
	);

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import bsp_pkg::*;

	typedef struct packed {
		logic              cmd;
		logic [NODE_W-1:0] node;
		logic [1:0]        slot;
		logic [NODE_W-1:0] successor;
		logic              succ_valid;
		logic [NODE_W-1:0] start_req;
		logic [NODE_W-1:0] end_node;
	} request_t;

	typedef struct packed {
		logic [NODE_W-1:0] path_node;
		logic              status;
		logic              last;
	} hop_t;

	typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	// Keeps a copy of the successor table and the path hops still owed by the engine.
	class path_tracker;
		bit              adj_ok [ADJ_DEPTH];
		bit [NODE_W-1:0] adj_to [ADJ_DEPTH];
		hop_t            pending [$];
		int              failures;

		function int waiting();
			return pending.size();
		endfunction

		function void trace_route(bit [NODE_W-1:0] from_node, bit [NODE_W-1:0] to_node);
			bit              seen [NODES];
			bit              linked [NODES];
			bit [NODE_W-1:0] parent [NODES];
			bit [NODE_W-1:0] fifo [NODES];
			bit [NODE_W-1:0] route [$];
			bit [NODE_W-1:0] cur;
			bit [NODE_W-1:0] nxt;
			hop_t            hop;
			int              head;
			int              tail;
			int              idx;
			int              k;
			bit              hit;
			for (k = 0; k < NODES; k++) begin
				seen[k] = 1'b0;
				linked[k] = 1'b0;
			end
			head = 0;
			tail = 0;
			hit = 1'b0;
			// The start is marked before the search, so a query to itself never hits.
			seen[from_node] = 1'b1;
			fifo[tail] = from_node;
			tail++;
			while (!hit && head < tail) begin
				cur = fifo[head];
				head++;
				for (k = 0; k < FANOUT; k++) begin
					idx = int'(cur) * FANOUT + k;
					if (!hit && adj_ok[idx] && !seen[adj_to[idx]]) begin
						nxt = adj_to[idx];
						seen[nxt] = 1'b1;
						linked[nxt] = 1'b1;
						parent[nxt] = cur;
						if (tail < NODES) begin
							fifo[tail] = nxt;
							tail++;
						end
						if (nxt == to_node)
							hit = 1'b1;
					end
				end
			end
			if (!hit) begin
				hop.path_node = '0;
				hop.status = STATUS_NC;
				hop.last = 1'b1;
				pending.insert(pending.size(), hop);
				return;
			end
			cur = to_node;
			while (linked[cur] && route.size() < NODES) begin
				route.push_front(parent[cur]);
				cur = parent[cur];
			end
			for (k = 0; k < route.size(); k++) begin
				hop.path_node = route[k];
				hop.status = STATUS_PATH;
				hop.last = (k == route.size() - 1);
				pending.insert(pending.size(), hop);
			end
		endfunction

		function void note_transfer(request_t rq);
			int idx;
			if (rq.cmd == CMD_LOAD) begin
				// Slot positions past the fanout are dropped by the engine.
				if (rq.slot < FANOUT) begin
					idx = int'(rq.node) * FANOUT + rq.slot;
					adj_ok[idx] = rq.succ_valid;
					adj_to[idx] = rq.succ_valid ? rq.successor : '0;
				end
			end else begin
				trace_route(rq.start_req, rq.end_node);
			end
		endfunction

		function void check_hop(logic [NODE_W-1:0] got_node, logic got_status,
				logic got_last);
			hop_t want;
			if (pending.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result", $realtime,
						" path_node %0d status %0d last %0d",
						got_node, got_status, got_last);
				return;
			end
			want = pending[0];
			pending.delete(0);
			if (got_node !== want.path_node || got_status !== want.status ||
					got_last !== want.last) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result mismatch: expected node %0d status %0d last %0d,",
						$realtime, want.path_node, want.status, want.last,
						" got node %0d status %0d last %0d",
						got_node, got_status, got_last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [NODE_W-1:0] node;
	logic [1:0]        slot;
	logic [NODE_W-1:0] successor;
	logic              succ_valid;
	logic [NODE_W-1:0] start_req;
	logic [NODE_W-1:0] end_node;
	logic              out_valid;
	logic              out_ready;
	logic [NODE_W-1:0] path_node;
	logic              status;
	logic              last;

	path_tracker     board = new();
	bit [NODE_W-1:0] trail [NODES];
	int              send_pct;
	int              stall_pct;
	int              hold_left;
	int              sent;

	bfs_shortest_path_engine u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// The receiver decides out_ready each cycle; a requested hold-off is counted down here.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_hop(path_node, status, last);
	end

	function automatic request_t scramble();
		request_t rq;
		rq.cmd = 1'($urandom_range(1));
		rq.node = NODE_W'($urandom_range(63));
		rq.slot = 2'($urandom_range(3));
		rq.successor = NODE_W'($urandom_range(63));
		rq.succ_valid = 1'($urandom_range(1));
		rq.start_req = NODE_W'($urandom_range(63));
		rq.end_node = NODE_W'($urandom_range(63));
		return rq;
	endfunction

	// Called just after a falling edge at which in_valid has not yet been assigned.
	task automatic offer(request_t rq);
		while (send_pct > 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= rq.cmd;
		node <= rq.node;
		slot <= rq.slot;
		successor <= rq.successor;
		succ_valid <= rq.succ_valid;
		start_req <= rq.start_req;
		end_node <= rq.end_node;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_transfer(rq);
		sent++;
		@(negedge clk);
	endtask

	task automatic load_slot(bit [NODE_W-1:0] n, bit [1:0] s, bit [NODE_W-1:0] to, bit ok);
		request_t rq;
		rq = scramble();
		rq.cmd = CMD_LOAD;
		rq.node = n;
		rq.slot = s;
		rq.successor = to;
		rq.succ_valid = ok;
		offer(rq);
	endtask

	task automatic ask_route(bit [NODE_W-1:0] from_node, bit [NODE_W-1:0] to_node);
		request_t rq;
		rq = scramble();
		rq.cmd = CMD_QUERY;
		rq.start_req = from_node;
		rq.end_node = to_node;
		offer(rq);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.waiting() != 0)
			@(negedge clk);
	endtask

	task automatic set_pace(pace_t pace);
		send_pct = (pace == PACE_SEND_GAPS) ? 67 : (pace == PACE_BOTH) ? 37 : 0;
		stall_pct = (pace == PACE_RECV_STALLS) ? 67 : (pace == PACE_BOTH) ? 37 : 0;
	endtask

	task automatic chain_query();
		ask_route(trail[$urandom_range(NODES - 1)], trail[$urandom_range(NODES - 1)]);
	endtask

	task automatic random_burst();
		bit [NODE_W-1:0] head_node;
		bit [NODE_W-1:0] prev;
		bit [NODE_W-1:0] nxt;
		int              pick;
		int              span;
		int              k;
		pick = $urandom_range(99);
		if (pick < 30) begin
			// A short linked run of loads followed by a query along it.
			span = $urandom_range(6, 2);
			prev = NODE_W'($urandom_range(63));
			head_node = prev;
			for (k = 0; k < span - 1; k++) begin
				nxt = NODE_W'($urandom_range(63));
				load_slot(prev, 2'($urandom_range(FANOUT - 1)), nxt, 1'b1);
				prev = nxt;
			end
			ask_route(head_node, prev);
		end else if (pick < 55) begin
			chain_query();
		end else if (pick < 78) begin
			load_slot(NODE_W'($urandom_range(63)), 2'($urandom_range(3)),
				NODE_W'($urandom_range(63)), 1'($urandom_range(1)));
		end else if (pick < 88) begin
			prev = NODE_W'($urandom_range(63));
			ask_route(prev, prev);
		end else begin
			ask_route(NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
		end
	endtask

	task automatic run_phase(pace_t pace, int quota);
		set_pace(pace);
		while (sent < quota)
			random_burst();
		settle();
	endtask

	initial begin
		int order [NODES];
		int k;
		int j;
		int tmp;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		node = '0;
		slot = '0;
		successor = '0;
		succ_valid = 1'b0;
		start_req = '0;
		end_node = '0;
		send_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty table, back edges, empty and ignored slots, self queries.
		ask_route(0, 1);
		load_slot(0, 0, 63, 1'b1);
		load_slot(63, 2, 5, 1'b1);
		load_slot(63, 0, 0, 1'b1);
		load_slot(63, 1, 42, 1'b0);
		load_slot(5, 3, 7, 1'b1);
		load_slot(5, 1, 63, 1'b1);
		ask_route(0, 5);
		ask_route(0, 0);
		ask_route(63, 0);
		ask_route(5, 7);
		ask_route(5, 0);
		ask_route(63, 63);
		ask_route(0, 42);
		load_slot(0, 0, 63, 1'b0);
		ask_route(0, 5);
		load_slot(63, 0, 0, 1'b0);
		load_slot(63, 2, 5, 1'b0);
		load_slot(5, 1, 63, 1'b0);
		settle();

		// One chain through every node gives the longest possible path.
		for (k = 0; k < NODES; k++)
			order[k] = k;
		for (k = NODES - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (k = 0; k < NODES; k++)
			trail[k] = NODE_W'(order[k]);
		for (k = 0; k < NODES - 1; k++)
			load_slot(trail[k], 2'($urandom_range(FANOUT - 1)), trail[k + 1], 1'b1);
		ask_route(trail[0], trail[NODES - 1]);

		// Long receiver hold-off while queries keep coming, so the input stalls.
		hold_left = 1500;
		for (k = 0; k < 12; k++)
			chain_query();
		settle();

		run_phase(PACE_SEND_GAPS, sent + 20);
		run_phase(PACE_RECV_STALLS, sent + 20);
		run_phase(PACE_BOTH, sent + 20);
		run_phase(PACE_FULL, sent + 15);

		repeat (40) @(negedge clk);
		if (board.failures == 0 && board.waiting() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
